// ----- sv/cre_pkg.sv -----
`timescale 1ns / 1ps
package cre_pkg;
    localparam int FB_WIDTH_DEF  = 128;
    localparam int FB_HEIGHT_DEF = 64;
    localparam logic [1:0] ACT_OUTLINE = 2'd0;
    localparam logic [1:0] ACT_FILLED  = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;
    localparam logic [15:0] FILL_RESET = 16'hffff;

    typedef struct packed {
        logic       we;
        logic       re;
        logic [7:0] wdata;
    } mem_ctl_t;
endpackage

// ----- sv/cre_frame_mem.sv -----
`timescale 1ns / 1ps
module cre_frame_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic              aclk,
    input  cre_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     raddr,
    input  logic [AW-1:0]     waddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[waddr] <= ctl.wdata;
        end
        if (ctl.re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- sv/circle_raster_engine_core.sv -----
`timescale 1ns / 1ps
// Channel | dir | tdata (low bit up)                                | tuser
// s_      | in  | center_x[15:0] center_y[15:0] radius[14:0]        | action[1:0]
//         |     | fb_address[9:0] fb_data[7:0] pad[6:0]             |
// m_      | out | read_data[7:0] drawn[0]                            | -
// Byte write/read: memory is accessed in ST_RD, the result registered in ST_RDW.
// Rejected draw: result registered from idle. Draw: per octant step, each candidate
// (8 outline, 4 filled) is checked in ST_STEP, with a read-modify-write per byte
// (ST_PIX, ST_MWAIT, ST_MWR) on the single frame memory port pair; ST_ADV advances.
// Reset is synchronous (aresetn low); frame memory is not cleared.
// A finished result waits in the output register; a new request is taken
// only after that register is free.
module circle_raster_engine_core #(
    parameter int FB_WIDTH  = cre_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = cre_pkg::FB_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // center_x, center_y, radius, fb_address, fb_data, 0
    input  logic [1:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data, drawn, 0
);
    localparam int PAGES = (FB_HEIGHT + 7) / 8;
    localparam int BYTES = FB_WIDTH * PAGES;
    localparam int AW    = $clog2(BYTES);
    localparam logic signed [17:0] W16 = 18'(FB_WIDTH * 16);
    localparam logic signed [17:0] H16 = 18'(FB_HEIGHT * 16);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_RDW   = 4'd2;
    localparam logic [3:0] ST_OUT   = 4'd3;
    localparam logic [3:0] ST_STEP  = 4'd4;
    localparam logic [3:0] ST_PIX   = 4'd5;
    localparam logic [3:0] ST_MWAIT = 4'd6;
    localparam logic [3:0] ST_MWR   = 4'd7;
    localparam logic [3:0] ST_ADV   = 4'd8;

    logic [3:0]  state_reg;
    logic [15:0] fill_reg;
    logic [1:0]  act_reg;
    logic [AW-1:0] addr_reg;
    logic        addr_ok_reg;
    logic [7:0]  wdat_reg;
    logic signed [17:0] cx_reg, cy_reg, x_reg, y_reg;
    logic signed [17:0] err_reg, esx_reg, esy_reg;
    logic [2:0]  k_reg;
    logic signed [17:0] col_reg, r0_reg, r1_reg;
    logic [5:0]  page_reg, p0_reg, p1_reg;
    logic [AW-1:0] maddr_reg;
    logic [7:0]  mask_reg, pat_reg;
    logic        out_v_reg;
    logic [7:0]  out_rd_reg;
    logic        out_dr_reg;
    logic [7:0]  rdata;
    cre_pkg::mem_ctl_t ctl;
    logic [AW-1:0] raddr;

    logic signed [15:0] in_cx, in_cy;
    logic [14:0] in_r;
    logic signed [17:0] in_cx_s, in_cy_s, in_r_s;
    assign in_cx = s_tdata[15:0];
    assign in_cy = s_tdata[31:16];
    assign in_r  = s_tdata[46:32];
    assign in_cx_s = 18'(in_cx);
    assign in_cy_s = 18'(in_cy);
    assign in_r_s  = $signed({3'b000, in_r});

    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_dr_reg, out_rd_reg};

    logic outline;
    assign outline = (act_reg == cre_pkg::ACT_OUTLINE);

    // candidate point or span for index k
    logic signed [17:0] pc, pr, sr0, sr1;
    always_comb begin
        pc = cx_reg; pr = cy_reg; sr0 = '0; sr1 = '0;
        if (outline) begin
            case (k_reg)
                3'd0: begin pc = cx_reg + x_reg; pr = cy_reg - y_reg; end
                3'd1: begin pc = cx_reg + x_reg; pr = cy_reg + y_reg; end
                3'd2: begin pc = cx_reg - x_reg; pr = cy_reg - y_reg; end
                3'd3: begin pc = cx_reg - x_reg; pr = cy_reg + y_reg; end
                3'd4: begin pc = cx_reg + y_reg; pr = cy_reg - x_reg; end
                3'd5: begin pc = cx_reg + y_reg; pr = cy_reg + x_reg; end
                3'd6: begin pc = cx_reg - y_reg; pr = cy_reg - x_reg; end
                default: begin pc = cx_reg - y_reg; pr = cy_reg + x_reg; end
            endcase
            sr0 = pr; sr1 = pr;
        end else begin
            case (k_reg[1:0])
                2'd0: begin pc = cx_reg + x_reg; sr0 = cy_reg - y_reg; sr1 = cy_reg + y_reg; end
                2'd1: begin pc = cx_reg - x_reg; sr0 = cy_reg - y_reg; sr1 = cy_reg + y_reg; end
                2'd2: begin pc = cx_reg + y_reg; sr0 = cy_reg - x_reg; sr1 = cy_reg + x_reg; end
                default: begin pc = cx_reg - y_reg; sr0 = cy_reg - x_reg; sr1 = cy_reg + x_reg; end
            endcase
        end
    end

    logic pix_ok;
    logic signed [17:0] c0, c1;
    assign pix_ok = (pc >= 0) && (pc < FB_WIDTH) && (sr0 <= sr1) && (sr1 >= 0)
                 && (sr0 < FB_HEIGHT);
    assign c0 = (sr0 < 0) ? 18'sd0 : sr0;
    assign c1 = (sr1 > FB_HEIGHT - 1) ? 18'(FB_HEIGHT - 1) : sr1;

    logic [7:0] pmask;
    always_comb begin
        pmask = 8'hff;
        if (page_reg == p0_reg) pmask = pmask & (8'hff << r0_reg[2:0]);
        if (page_reg == p1_reg) pmask = pmask & (8'hff >> (3'd7 - r1_reg[2:0]));
    end

    logic [AW+7:0] page_addr;
    assign page_addr = (AW+8)'(page_reg) * (AW+8)'(FB_WIDTH) + (AW+8)'(col_reg[8:0]);

    logic last_k;
    assign last_k = outline ? (k_reg == 3'd7) : (k_reg == 3'd3);

    logic signed [17:0] r_pix;
    assign r_pix = 18'(in_r[14:4]);

    always_comb begin
        ctl.we = 1'b0;
        ctl.re = 1'b0;
        ctl.wdata = wdat_reg;
        raddr = addr_reg;
        if (state_reg == ST_RD) begin
            ctl.re = (act_reg == cre_pkg::ACT_READ);
            ctl.we = (act_reg == cre_pkg::ACT_WRITE) && addr_ok_reg;
        end else if (state_reg == ST_PIX) begin
            raddr = maddr_reg;
        end else if (state_reg == ST_MWAIT) begin
            raddr = maddr_reg;
            ctl.re = 1'b1;
        end else if (state_reg == ST_MWR) begin
            ctl.we = 1'b1;
            ctl.wdata = (rdata & ~mask_reg) | (pat_reg & mask_reg);
        end
    end

    cre_frame_mem #(.DEPTH(BYTES), .AW(AW)) u_mem (
        .aclk(aclk), .ctl(ctl), .raddr(raddr),
        .waddr((state_reg == ST_MWR) ? maddr_reg : addr_reg), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= cre_pkg::FILL_RESET;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) fill_reg <= cfg_wdata;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        act_reg  <= s_tuser;
                        addr_reg <= AW'(s_tdata[56:47]);
                        addr_ok_reg <= 32'(s_tdata[56:47]) < BYTES;
                        wdat_reg <= s_tdata[64:57];
                        if (s_tuser == cre_pkg::ACT_WRITE || s_tuser == cre_pkg::ACT_READ) begin
                            state_reg <= ST_RD;
                        end else if ((in_cx_s < -in_r_s) || (in_cy_s < -in_r_s)
                                  || (in_cx_s > W16 + in_r_s)
                                  || (in_cy_s > H16 + in_r_s)) begin
                            out_rd_reg <= 8'd0;
                            out_dr_reg <= 1'b0;
                            out_v_reg  <= 1'b1;
                        end else begin
                            cx_reg  <= 18'(in_cx >>> 4);
                            cy_reg  <= 18'(in_cy >>> 4);
                            x_reg   <= '0;
                            y_reg   <= r_pix;
                            esx_reg <= 18'sd12;
                            esy_reg <= 18'sd8 - (r_pix <<< 3);
                            err_reg <= 18'sd5 - (r_pix <<< 2);
                            k_reg   <= '0;
                            state_reg <= (r_pix >= 0) ? ST_STEP : ST_OUT;
                        end
                    end
                end
                ST_RD: state_reg <= ST_RDW;
                ST_RDW: begin
                    out_rd_reg <= (act_reg == cre_pkg::ACT_READ && addr_ok_reg) ? rdata : 8'd0;
                    out_dr_reg <= 1'b0;
                    out_v_reg  <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                ST_OUT: begin
                    out_rd_reg <= 8'd0;
                    out_dr_reg <= 1'b1;
                    out_v_reg  <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                ST_STEP: begin
                    // pick next element k
                    if (pix_ok) begin
                        col_reg <= pc;
                        r0_reg  <= c0;
                        r1_reg  <= c1;
                        p0_reg  <= 6'(c0 >>> 3);
                        p1_reg  <= 6'(c1 >>> 3);
                        page_reg <= 6'(c0 >>> 3);
                        pat_reg <= outline ? 8'd0 : (pc[0] ? fill_reg[7:0] : fill_reg[15:8]);
                        state_reg <= ST_PIX;
                    end else if (last_k) begin
                        state_reg <= ST_ADV;
                    end else begin
                        k_reg <= k_reg + 3'd1;
                    end
                end
                ST_PIX: begin
                    maddr_reg <= AW'(page_addr);
                    mask_reg  <= pmask;
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT: state_reg <= ST_MWR;
                ST_MWR: begin
                    if (page_reg != p1_reg) begin
                        page_reg  <= page_reg + 6'd1;
                        state_reg <= ST_PIX;
                    end else if (last_k) begin
                        state_reg <= ST_ADV;
                    end else begin
                        k_reg <= k_reg + 3'd1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_ADV: begin
                    k_reg <= '0;
                    if (err_reg >= 0) begin
                        err_reg <= err_reg + esy_reg + esx_reg;
                        esy_reg <= esy_reg + 18'sd8;
                        y_reg   <= y_reg - 18'sd1;
                        state_reg <= (x_reg + 18'sd1 <= y_reg - 18'sd1) ? ST_STEP : ST_OUT;
                    end else begin
                        err_reg <= err_reg + esx_reg;
                        state_reg <= (x_reg + 18'sd1 <= y_reg) ? ST_STEP : ST_OUT;
                    end
                    esx_reg <= esx_reg + 18'sd8;
                    x_reg   <= x_reg + 18'sd1;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/cre_checker.sv -----
`timescale 1ns / 1ps
module cre_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0) else $error("pad bits set");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[7:0] != 8'd0)) else $error("both fields set");
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("double accept");
endmodule

bind circle_raster_engine_core cre_checker u_cre_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- dv/circle_raster_scoreboard.sv -----
`timescale 1ns / 1ps
module circle_raster_scoreboard #(
    parameter int FB_WIDTH  = cre_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = cre_pkg::FB_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,  // center_x, center_y, radius, fb_address, fb_data, 0
    input  logic [1:0]  s_tuser,  // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,  // read_data, drawn, 0
    output int          failures,
    output int          pending
);
    localparam int FB_BYTES = FB_WIDTH * ((FB_HEIGHT + 7) / 8);

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
    } raster_result_t;

    logic [7:0]     frame_model [FB_BYTES];
    logic [15:0]    fill_model;
    raster_result_t expected_results [$];

    assign pending = expected_results.size();

    task automatic erase_dot(input int col, input int row);
        if (col >= 0 && col < FB_WIDTH && row >= 0 && row < FB_HEIGHT) begin
            frame_model[(row >> 3) * FB_WIDTH + col][row & 7] = 1'b0;
        end
    endtask

    task automatic paint_span(input int col, input int r0, input int r1);
        int         page;
        int         p0;
        int         p1;
        logic [7:0] pat;
        logic [7:0] m;
        if (r0 > r1 || r1 < 0 || r0 >= FB_HEIGHT) return;
        if (col < 0 || col >= FB_WIDTH) return;
        if (r0 < 0) r0 = 0;
        if (r1 > FB_HEIGHT - 1) r1 = FB_HEIGHT - 1;
        pat = col[0] ? fill_model[7:0] : fill_model[15:8];
        p0 = r0 >> 3;
        p1 = r1 >> 3;
        for (page = p0; page <= p1; page++) begin
            m = 8'hff;
            if (page == p0) m = m & (8'hff << (r0 & 7));
            if (page == p1) m = m & (8'hff >> (7 - (r1 & 7)));
            frame_model[page * FB_WIDTH + col] =
                (frame_model[page * FB_WIDTH + col] & ~m) | (pat & m);
        end
    endtask

    function automatic logic circle_visible(input int cxr, input int cyr, input int rr);
        if (cxr < -rr || cyr < -rr) return 1'b0;
        if (cxr > FB_WIDTH * 16 + rr || cyr > FB_HEIGHT * 16 + rr) return 1'b0;
        return 1'b1;
    endfunction

    task automatic rasterize_circle(input int cxr, input int cyr, input int rr,
                                    input logic filled);
        int cx;
        int cy;
        int x;
        int y;
        int err;
        int dex;
        int dey;
        cx  = cxr >>> 4;
        cy  = cyr >>> 4;
        y   = rr >> 4;
        dex = 12;
        dey = 8 - y * 8;
        err = 5 - y * 4;
        for (x = 0; x <= y; x++) begin
            if (filled) begin
                paint_span(cx + x, cy - y, cy + y);
                paint_span(cx - x, cy - y, cy + y);
                paint_span(cx + y, cy - x, cy + x);
                paint_span(cx - y, cy - x, cy + x);
            end else begin
                erase_dot(cx + x, cy - y);
                erase_dot(cx + x, cy + y);
                erase_dot(cx - x, cy - y);
                erase_dot(cx - x, cy + y);
                erase_dot(cx + y, cy - x);
                erase_dot(cx + y, cy + x);
                erase_dot(cx - y, cy - x);
                erase_dot(cx - y, cy + x);
            end
            if (err >= 0) begin
                err = err + dey;
                dey = dey + 8;
                y   = y - 1;
            end
            err = err + dex;
            dex = dex + 8;
        end
    endtask

    task automatic predict_request(input logic [1:0] act, input logic [71:0] d,
                                   output raster_result_t res);
        int         cxr;
        int         cyr;
        int         rr;
        int         addr;
        cxr = int'($signed(d[15:0]));
        cyr = int'($signed(d[31:16]));
        rr  = int'(d[46:32]);
        addr = int'(d[56:47]);
        res = '0;
        case (act)
            cre_pkg::ACT_OUTLINE, cre_pkg::ACT_FILLED: begin
                res.drawn = circle_visible(cxr, cyr, rr);
                if (res.drawn) rasterize_circle(cxr, cyr, rr, act == cre_pkg::ACT_FILLED);
            end
            cre_pkg::ACT_WRITE: begin
                if (addr < FB_BYTES) frame_model[addr] = d[64:57];
            end
            default: begin
                if (addr < FB_BYTES) res.read_data = frame_model[addr];
            end
        endcase
    endtask

    initial begin
        failures = 0;
        fill_model = cre_pkg::FILL_RESET;
        foreach (frame_model[i]) frame_model[i] = 8'h00;
    end

    always @(posedge aclk) begin
        raster_result_t res;
        raster_result_t want;
        if (!aresetn) begin
            fill_model = cre_pkg::FILL_RESET;
            expected_results.delete();
        end else begin
            if (cfg_we) fill_model = cfg_wdata;
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata, res);
                expected_results.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result read_data=%02h drawn=%0b",
                             $time, m_tdata[7:0], m_tdata[8]);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want.read_data) begin
                        $display("%0t: read_data mismatch expected %02h actual %02h",
                                 $time, want.read_data, m_tdata[7:0]);
                        failures++;
                    end
                    if (m_tdata[8] !== want.drawn) begin
                        $display("%0t: drawn mismatch expected %0b actual %0b",
                                 $time, want.drawn, m_tdata[8]);
                        failures++;
                    end
                    if (m_tdata[15:9] !== 7'd0) begin
                        $display("%0t: pad mismatch expected 00 actual %02h",
                                 $time, m_tdata[15:9]);
                        failures++;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/circle_raster_engine_core_tb.sv -----
`timescale 1ns / 1ps
module circle_raster_engine_core_tb;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int DRAIN_CYCLES   = 64;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int   failures;
    int   pending;
    int   tx_idle;
    int   rx_idle;
    int   quiet_cycles = 0;
    logic s_acc;
    int   written_addrs [$];
    bit   written [1024];

    circle_raster_engine_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    circle_raster_scoreboard scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .failures  (failures),
        .pending   (pending)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        s_acc <= s_tvalid && s_tready;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send_request(input logic [1:0] act, input int cx, input int cy,
                                input int rad, input int addr, input int data);
        logic [15:0] cx_v;
        logic [15:0] cy_v;
        logic [14:0] rad_v;
        logic [9:0]  addr_v;
        logic [7:0]  data_v;
        cx_v   = cx[15:0];
        cy_v   = cy[15:0];
        rad_v  = rad[14:0];
        addr_v = addr[9:0];
        data_v = data[7:0];
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser  = act;
        s_tdata  = {7'd0, data_v, addr_v, rad_v, cy_v, cx_v};
        s_tvalid = 1'b1;
        do @(negedge aclk); while (!s_acc);
        if (act == cre_pkg::ACT_WRITE && !written[addr_v]) begin
            written[addr_v] = 1'b1;
            written_addrs.push_back(int'(addr_v));
        end
    endtask

    task automatic read_back(input int fallback_data);
        if (written_addrs.size() == 0) begin
            send_request(cre_pkg::ACT_WRITE, 0, 0, 0, $urandom_range(1023), fallback_data);
        end else begin
            send_request(cre_pkg::ACT_READ, $urandom, $urandom, $urandom,
                         written_addrs[$urandom_range(written_addrs.size() - 1)],
                         $urandom);
        end
    endtask

    task automatic drain_and_configure(input logic [15:0] pattern);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wdata = pattern;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_request();
        int pick;
        int rad;
        pick = $urandom_range(99);
        rad  = ($urandom_range(9) < 8) ? $urandom_range(0, 400) : $urandom_range(0, 1200);
        if (pick < 25) begin
            send_request(cre_pkg::ACT_WRITE, $urandom, $urandom, $urandom,
                         $urandom_range(1023), $urandom);
        end else if (pick < 45) begin
            read_back($urandom);
        end else if (pick < 90) begin
            send_request((pick < 68) ? cre_pkg::ACT_OUTLINE : cre_pkg::ACT_FILLED,
                         int'($urandom_range(0, 2600)) - 300,
                         int'($urandom_range(0, 1500)) - 250,
                         rad, $urandom, $urandom);
        end else if (pick < 95) begin
            send_request(2'($urandom_range(1)), $urandom, $urandom,
                         $urandom_range(0, 2047), $urandom, $urandom);
        end else begin
            send_request(2'($urandom_range(1)), -32768, $urandom, $urandom, $urandom,
                         $urandom);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 16'h0000;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = cre_pkg::ACT_OUTLINE;
        m_tready  = 1'b0;
        tx_idle   = 18;
        rx_idle   = 72;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        drain_and_configure(16'haa55);

        send_request(cre_pkg::ACT_WRITE, 0, 0, 0, 0, 8'h00);
        send_request(cre_pkg::ACT_WRITE, 0, 0, 0, 1023, 8'hff);
        for (int i = 0; i < 1024; i += 37) begin
            send_request(cre_pkg::ACT_WRITE, 0, 0, 0, i, $urandom);
        end
        send_request(cre_pkg::ACT_READ, 0, 0, 0, 0, 0);
        send_request(cre_pkg::ACT_READ, 0, 0, 0, 1023, 0);
        send_request(cre_pkg::ACT_OUTLINE, 0, 0, 0, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 1024, 512, 160, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, -161, 500, 160, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, 500, -161, 160, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 2048 + 161, 500, 160, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 500, 1024 + 161, 160, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, -160, -160, 160, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 2048 + 160, 1024 + 160, 160, 0, 0);
        send_request(cre_pkg::ACT_FILLED, -17, -9, 300, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, 32767, 32767, 100, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, -32768, -32768, 32767, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 1000, 2000, 800, 0, 0);
        send_request(cre_pkg::ACT_OUTLINE, 1024, 512, 32767, 0, 0);
        send_request(cre_pkg::ACT_FILLED, 1024, 512, 32767, 0, 0);
        for (int i = 0; i < 1024; i += 37) send_request(cre_pkg::ACT_READ, 0, 0, 0, i, 0);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle = 18;
                    rx_idle = 72;
                    drain_and_configure(16'h0000);
                end
                1: begin
                    tx_idle = 72;
                    rx_idle = 18;
                    drain_and_configure(16'hffff);
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                    drain_and_configure(16'($urandom));
                end
            endcase
            repeat (460) random_request();
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/cre_pkg.sv
sv/cre_frame_mem.sv
sv/circle_raster_engine_core.sv
sv/cre_checker.sv
dv/circle_raster_scoreboard.sv
dv/circle_raster_engine_core_tb.sv
